>>> rtl/bftm_pkg.sv
// ----------------------------------------------------------------------------
// bftm_pkg: shared definitions of the tape machine core
// Sizes, derived widths, instruction bytes, status and mode codes, stack control.
// ----------------------------------------------------------------------------
package bftm_pkg;

   localparam int PROG_DEPTH = 4096;
   localparam int TAPE_DEPTH = 4096;
   localparam int NEST_DEPTH = 32;

   localparam int PAW = $clog2(PROG_DEPTH);
   localparam int LW  = $clog2(PROG_DEPTH + 1);
   localparam int TAW = $clog2(TAPE_DEPTH);
   localparam int SAW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
   localparam int DW  = $clog2(NEST_DEPTH + 1);

   localparam logic [7:0] OP_INC   = 8'h2B;
   localparam logic [7:0] OP_DEC   = 8'h2D;
   localparam logic [7:0] OP_RIGHT = 8'h3E;
   localparam logic [7:0] OP_LEFT  = 8'h3C;
   localparam logic [7:0] OP_OUT   = 8'h2E;
   localparam logic [7:0] OP_IN    = 8'h2C;
   localparam logic [7:0] OP_OPEN  = 8'h5B;
   localparam logic [7:0] OP_CLOSE = 8'h5D;

   localparam logic [2:0] STAT_RUN       = 3'd0;
   localparam logic [2:0] STAT_DONE      = 3'd1;
   localparam logic [2:0] STAT_UNDER     = 3'd2;
   localparam logic [2:0] STAT_OVER      = 3'd3;
   localparam logic [2:0] STAT_UNMATCHED = 3'd4;
   localparam logic [2:0] STAT_FULL      = 3'd5;

   localparam logic [1:0] MODE_APPEND  = 2'd0;
   localparam logic [1:0] MODE_EXEC    = 2'd1;
   localparam logic [1:0] MODE_RESTART = 2'd2;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } stack_ctl_type;

endpackage

>>> rtl/bftm_if.sv
// ----------------------------------------------------------------------------
// bftm_req_if / bftm_rsp_if: valid-ready channels of the core
// One beat moves one step request or one step result.
// ----------------------------------------------------------------------------
interface bftm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] code_byte;
   logic [7:0] input_byte;
   modport source (output valid, mode, code_byte, input_byte, input ready);
   modport sink   (input valid, mode, code_byte, input_byte, output ready);
endinterface

interface bftm_rsp_if;
   logic       valid;
   logic       ready;
   logic       out_valid;
   logic [7:0] out_byte;
   logic       input_taken;
   logic [2:0] status;
   modport source (output valid, out_valid, out_byte, input_taken, status, input ready);
   modport sink   (input valid, out_valid, out_byte, input_taken, status, output ready);
endinterface

>>> rtl/bf_tape_machine_core.sv
// ----------------------------------------------------------------------------
// bf_tape_machine_core: eight-instruction tape machine around two memories
// An append or no-op step goes from IDLE to RESP; an instruction goes through
// EXEC, which acts on the registered read of program and tape memory; a
// forward skip at '[' walks the program bytes through the SCAN_RD/SCAN_CHK
// pair. A restart runs the tape clearing sweep before RESP. After reset the
// sweep runs with req_bus.ready low; one request is worked on at a time.
// ----------------------------------------------------------------------------
module bf_tape_machine_core (
   input logic         clock,
   input logic         reset,
   bftm_req_if.sink    req_bus,
   bftm_rsp_if.source  rsp_bus
);
   import bftm_pkg::*;

   // One-hot sequencer. CLEAR zeroes the tape one cell per cycle, EXEC acts
   // on the memory read data of the fetched instruction, the SCAN pair walks
   // the program for the matching bracket, and RESP hands the result to the
   // output register.
   typedef enum logic [5:0] {
      S_CLEAR    = 6'b000001,
      S_IDLE     = 6'b000010,
      S_EXEC     = 6'b000100,
      S_SCAN_RD  = 6'b001000,
      S_SCAN_CHK = 6'b010000,
      S_RESP     = 6'b100000
   } state_type;

   state_type      state_ff, state_in;
   logic [LW-1:0]  pc_ff, pc_in;
   logic [LW-1:0]  len_ff, len_in;
   logic [TAW-1:0] dp_ff, dp_in;
   logic [2:0]     status_ff, status_in;
   logic [TAW-1:0] clr_ff, clr_in;
   logic           clr_resp_ff, clr_resp_in;
   logic [7:0]     ib_ff, ib_in;
   logic [LW-1:0]  scan_ff, scan_in;
   logic [LW-1:0]  level_ff, level_in;
   logic           ov_ff, ov_in;
   logic [7:0]     ob_ff, ob_in;
   logic           it_ff, it_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic           prog_we;
   logic [PAW-1:0] prog_raddr;
   logic [7:0]     prog_rdata;
   logic           tape_we;
   logic [TAW-1:0] tape_waddr;
   logic [7:0]     tape_wdata;
   logic [7:0]     tape_rdata;

   stack_ctl_type  stk_ctl;
   logic [DW-1:0]  stk_depth;
   logic [PAW-1:0] stk_top;

   logic           accept;
   logic           is_err;
   logic           rsp_load;
   logic [LW-1:0]  pc_new;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign is_err        = (status_ff >= STAT_UNDER);
   assign rsp_load      = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_bus.ready);

   // The program is written at the fill count and read at the program
   // counter, or at the scan address while walking forward.
   assign prog_we    = accept && (req_bus.mode == MODE_APPEND) &&
                       (len_ff < LW'(PROG_DEPTH));
   assign prog_raddr = (state_ff == S_SCAN_RD) ? scan_ff[PAW-1:0] : pc_ff[PAW-1:0];

   bftm_ram #(.DEPTH(PROG_DEPTH), .WIDTH(8)) u_prog (
      .clock (clock),
      .we    (prog_we),
      .waddr (len_ff[PAW-1:0]),
      .wdata (req_bus.code_byte),
      .raddr (prog_raddr),
      .rdata (prog_rdata)
   );

   // The tape is always read at the data pointer. Each instruction writes
   // at most once, in EXEC, and the next read is issued no earlier than the
   // following cycle, so no forwarding is needed.
   bftm_ram #(.DEPTH(TAPE_DEPTH), .WIDTH(8)) u_tape (
      .clock (clock),
      .we    (tape_we),
      .waddr (tape_waddr),
      .wdata (tape_wdata),
      .raddr (dp_ff),
      .rdata (tape_rdata)
   );

   bftm_stack u_stack (
      .clock     (clock),
      .reset     (reset),
      .ctl       (stk_ctl),
      .push_data (pc_ff[PAW-1:0]),
      .depth     (stk_depth),
      .top       (stk_top)
   );

   always_comb begin
      state_in    = state_ff;
      pc_in       = pc_ff;
      len_in      = len_ff;
      dp_in       = dp_ff;
      status_in   = status_ff;
      clr_in      = clr_ff;
      clr_resp_in = clr_resp_ff;
      ib_in       = ib_ff;
      scan_in     = scan_ff;
      level_in    = level_ff;
      ov_in       = ov_ff;
      ob_in       = ob_ff;
      it_in       = it_ff;
      tape_we     = 1'b0;
      tape_waddr  = dp_ff;
      tape_wdata  = tape_rdata;
      stk_ctl     = '0;
      pc_new      = pc_ff;

      case (state_ff)
         S_CLEAR: begin
            tape_we    = 1'b1;
            tape_waddr = clr_ff;
            tape_wdata = 8'h00;
            clr_in     = clr_ff + TAW'(1);
            if (clr_ff == TAW'(TAPE_DEPTH - 1)) begin
               clr_in   = '0;
               state_in = clr_resp_ff ? S_RESP : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               ov_in    = 1'b0;
               ob_in    = 8'h00;
               it_in    = 1'b0;
               ib_in    = req_bus.input_byte;
               state_in = S_RESP;
               case (req_bus.mode)
                  MODE_APPEND: begin
                     if (len_ff < LW'(PROG_DEPTH)) begin
                        len_in = len_ff + LW'(1);
                        if (status_ff == STAT_DONE) begin
                           status_in = STAT_RUN;
                        end
                     end else if (!is_err) begin
                        status_in = STAT_FULL;
                     end
                  end
                  MODE_EXEC: begin
                     if (!is_err) begin
                        if (pc_ff >= len_ff) begin
                           status_in = STAT_DONE;
                        end else begin
                           state_in = S_EXEC;
                        end
                     end
                  end
                  MODE_RESTART: begin
                     pc_in         = '0;
                     dp_in         = '0;
                     status_in     = STAT_RUN;
                     stk_ctl.clear = 1'b1;
                     clr_resp_in   = 1'b1;
                     state_in      = S_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
            pc_new   = pc_ff + LW'(1);
            case (prog_rdata)
               OP_INC: begin
                  tape_we    = 1'b1;
                  tape_wdata = tape_rdata + 8'd1;
               end
               OP_DEC: begin
                  tape_we    = 1'b1;
                  tape_wdata = tape_rdata - 8'd1;
               end
               OP_RIGHT: begin
                  if (dp_ff == TAW'(TAPE_DEPTH - 1)) begin
                     status_in = STAT_OVER;
                     pc_new    = pc_ff;
                  end else begin
                     dp_in = dp_ff + TAW'(1);
                  end
               end
               OP_LEFT: begin
                  if (dp_ff == '0) begin
                     status_in = STAT_UNDER;
                     pc_new    = pc_ff;
                  end else begin
                     dp_in = dp_ff - TAW'(1);
                  end
               end
               OP_OUT: begin
                  ov_in = 1'b1;
                  ob_in = tape_rdata;
               end
               OP_IN: begin
                  it_in      = 1'b1;
                  tape_we    = 1'b1;
                  tape_wdata = ib_ff;
               end
               OP_OPEN: begin
                  if (tape_rdata != 8'h00) begin
                     if (stk_depth == DW'(NEST_DEPTH)) begin
                        status_in = STAT_FULL;
                        pc_new    = pc_ff;
                     end else begin
                        stk_ctl.push = 1'b1;
                     end
                  end else begin
                     // Zero cell: walk forward for the matching bracket.
                     pc_new   = pc_ff;
                     scan_in  = pc_ff + LW'(1);
                     level_in = LW'(1);
                     state_in = S_SCAN_RD;
                  end
               end
               OP_CLOSE: begin
                  if (stk_depth == '0) begin
                     status_in = STAT_UNMATCHED;
                     pc_new    = pc_ff;
                  end else if (tape_rdata != 8'h00) begin
                     pc_new = LW'(stk_top) + LW'(1);
                  end else begin
                     stk_ctl.pop = 1'b1;
                  end
               end
               default: begin
               end
            endcase
            pc_in = pc_new;
            if ((state_in == S_RESP) && (status_in == STAT_RUN) && (pc_new >= len_ff)) begin
               status_in = STAT_DONE;
            end
         end
         S_SCAN_RD: begin
            if (scan_ff >= len_ff) begin
               status_in = STAT_UNMATCHED;
               state_in  = S_RESP;
            end else begin
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            state_in = S_SCAN_RD;
            scan_in  = scan_ff + LW'(1);
            if (prog_rdata == OP_OPEN) begin
               level_in = level_ff + LW'(1);
            end else if (prog_rdata == OP_CLOSE) begin
               level_in = level_ff - LW'(1);
               if (level_ff == LW'(1)) begin
                  pc_in    = scan_ff + LW'(1);
                  state_in = S_RESP;
                  if (scan_ff + LW'(1) >= len_ff) begin
                     status_in = STAT_DONE;
                  end
               end
            end
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The result register frees the sequencer from a stalled sink.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         pc_ff        <= '0;
         len_ff       <= '0;
         dp_ff        <= '0;
         status_ff    <= STAT_RUN;
         clr_ff       <= '0;
         clr_resp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         len_ff       <= len_in;
         dp_ff        <= dp_in;
         status_ff    <= status_in;
         clr_ff       <= clr_in;
         clr_resp_ff  <= clr_resp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ib_ff    <= ib_in;
      scan_ff  <= scan_in;
      level_ff <= level_in;
      ov_ff    <= ov_in;
      ob_ff    <= ob_in;
      it_ff    <= it_in;
      if (rsp_load) begin
         rsp_bus.out_valid   <= ov_ff;
         rsp_bus.out_byte    <= ob_ff;
         rsp_bus.input_taken <= it_ff;
         rsp_bus.status      <= status_ff;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;

endmodule

>>> rtl/bftm_ram.sv
// ----------------------------------------------------------------------------
// bftm_ram: generic single-write, single-read synchronous RAM
// Read data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module bftm_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

>>> rtl/bftm_stack.sv
// ----------------------------------------------------------------------------
// bftm_stack: bracket stack of loop start addresses
// Holds the depth count; the top entry is read combinationally.
// ----------------------------------------------------------------------------
module bftm_stack (
   input  logic                   clock,
   input  logic                   reset,
   input  bftm_pkg::stack_ctl_type ctl,
   input  logic [bftm_pkg::PAW-1:0] push_data,
   output logic [bftm_pkg::DW-1:0]  depth,
   output logic [bftm_pkg::PAW-1:0] top
);
   import bftm_pkg::*;

   logic [PAW-1:0] entry_ff [NEST_DEPTH];
   logic [DW-1:0]  depth_ff;
   logic [DW-1:0]  depth_in;
   logic [DW-1:0]  top_idx;

   assign top_idx = depth_ff - DW'(1);
   assign top     = entry_ff[top_idx[SAW-1:0]];
   assign depth   = depth_ff;

   always_comb begin
      depth_in = depth_ff;
      if (ctl.clear) begin
         depth_in = '0;
      end else if (ctl.push) begin
         depth_in = depth_ff + DW'(1);
      end else if (ctl.pop) begin
         depth_in = depth_ff - DW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         entry_ff[depth_ff[SAW-1:0]] <= push_data;
      end
   end
endmodule

>>> rtl/bftm_checker.sv
// ----------------------------------------------------------------------------
// bftm_checker: port-level assertions for the tape machine core
// Bound to the core module; watches the request and result channels.
// ----------------------------------------------------------------------------
module bftm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_out_valid,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_input_taken,
   input logic [2:0] rsp_status
);
   // A request beat is worked on before the next one is taken.
   a_req_single: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken on consecutive cycles");

   // A step never both emits and consumes a byte.
   a_io_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_out_valid && rsp_input_taken))
      else $error("output and input taken in one step");

   // Status codes stay within the defined set.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= 3'd5))
      else $error("status code out of range");

   // Only an output step carries a nonzero byte.
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_valid) |-> (rsp_out_byte == 8'h00))
      else $error("byte without output");

   // A stalled result beat stays valid with its status unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)))
      else $error("stalled result changed");
endmodule

bind bf_tape_machine_core bftm_checker u_bftm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_out_valid   (rsp_bus.out_valid),
   .rsp_out_byte    (rsp_bus.out_byte),
   .rsp_input_taken (rsp_bus.input_taken),
   .rsp_status      (rsp_bus.status)
);

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench of the tape machine core
// Guarded program blocks are appended and run step by step. Every step
// request is fed to a scoreboard that predicts the step result, and every
// result beat is compared with that prediction field by field.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bftm_pkg::*;

   // The fourth mode value is a no-op step that only reports the status.
   localparam logic [1:0] MODE_IDLE = 2'd3;
   localparam int ITEMS = 1700;
   localparam int WATCHDOG_LIMIT = 40000;

   typedef struct {
      bit       out_valid;
      bit [7:0] out_byte;
      bit       input_taken;
      bit [2:0] status;
   } step_result_type;

   // The scoreboard keeps its own copy of the machine. Its state is public
   // so that the stimulus can steer the run from what the machine will do.
   class tape_scoreboard;
      bit [7:0]        store[PROG_DEPTH];
      bit [7:0]        tape[TAPE_DEPTH];
      int              call_stack[NEST_DEPTH];
      int              plen;
      int              pc;
      int              dp;
      int              depth;
      bit [2:0]        st;
      step_result_type want[$];
      int              n_bad;
      int              n_checked;

      function void note_request(logic [1:0] mode, logic [7:0] code, logic [7:0] in_byte);
         step_result_type r;
         int              npc;
         int              j;
         int              lvl;
         bit              moved;
         r = '{1'b0, 8'd0, 1'b0, 3'd0};
         case (mode)
            MODE_APPEND: begin
               if (plen < PROG_DEPTH) begin
                  store[plen] = code;
                  plen++;
                  if (st == STAT_DONE) st = STAT_RUN;
               end else if (st < STAT_UNDER) begin
                  st = STAT_FULL;
               end
            end
            MODE_EXEC: begin
               if (st >= STAT_UNDER) begin
                  // Sticky error: the step does nothing.
               end else if (pc >= plen) begin
                  st = STAT_DONE;
               end else begin
                  npc = pc + 1;
                  moved = 1'b1;
                  case (store[pc])
                     OP_INC: tape[dp] = tape[dp] + 8'd1;
                     OP_DEC: tape[dp] = tape[dp] - 8'd1;
                     OP_RIGHT: begin
                        if (dp + 1 >= TAPE_DEPTH) begin
                           st = STAT_OVER;
                           moved = 1'b0;
                        end else dp++;
                     end
                     OP_LEFT: begin
                        if (dp == 0) begin
                           st = STAT_UNDER;
                           moved = 1'b0;
                        end else dp--;
                     end
                     OP_OUT: begin
                        r.out_valid = 1'b1;
                        r.out_byte = tape[dp];
                     end
                     OP_IN: begin
                        r.input_taken = 1'b1;
                        tape[dp] = in_byte;
                     end
                     OP_OPEN: begin
                        if (tape[dp] != 8'd0) begin
                           if (depth >= NEST_DEPTH) begin
                              st = STAT_FULL;
                              moved = 1'b0;
                           end else begin
                              call_stack[depth] = pc;
                              depth++;
                           end
                        end else begin
                           // Walk forward to the matching close bracket.
                           j = pc + 1;
                           lvl = 1;
                           while (j < plen && lvl != 0) begin
                              if (store[j] == OP_OPEN) lvl++;
                              else if (store[j] == OP_CLOSE) lvl--;
                              if (lvl != 0) j++;
                           end
                           if (lvl != 0) begin
                              st = STAT_UNMATCHED;
                              moved = 1'b0;
                           end else npc = j + 1;
                        end
                     end
                     OP_CLOSE: begin
                        if (depth == 0) begin
                           st = STAT_UNMATCHED;
                           moved = 1'b0;
                        end else if (tape[dp] != 8'd0) begin
                           npc = call_stack[depth - 1] + 1;
                        end else depth--;
                     end
                     default: ;
                  endcase
                  if (moved) begin
                     pc = npc;
                     if (pc >= plen) st = STAT_DONE;
                  end
               end
            end
            MODE_RESTART: begin
               foreach (tape[i]) tape[i] = 8'd0;
               dp = 0;
               pc = 0;
               depth = 0;
               st = STAT_RUN;
            end
            default: ;
         endcase
         r.status = st;
         want.push_back(r);
      endfunction

      function void check_result(logic ov, logic [7:0] ob, logic it, logic [2:0] stat);
         step_result_type e;
         if (want.size() == 0) begin
            $error("result beat with no step outstanding: status %0d", stat);
            n_bad++;
            return;
         end
         e = want.pop_front();
         n_checked++;
         if (ov !== e.out_valid) begin
            $error("out_valid: expected %0d, actual %0d", e.out_valid, ov);
            n_bad++;
         end
         if (ob !== e.out_byte) begin
            $error("out_byte: expected %0d, actual %0d", e.out_byte, ob);
            n_bad++;
         end
         if (it !== e.input_taken) begin
            $error("input_taken: expected %0d, actual %0d", e.input_taken, it);
            n_bad++;
         end
         if (stat !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, stat);
            n_bad++;
         end
      endfunction

      function int pending();
         return want.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   bftm_req_if req_bus ();
   bftm_rsp_if rsp_bus ();

   bf_tape_machine_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   tape_scoreboard sb = new();

   // Every program block is wrapped as ",[ body ]". The ',' of such a wrapper
   // is a guard: fed zero it makes the '[' skip the whole block in one step,
   // fed a nonzero byte it enters the block. Replays after a restart skip all
   // blocks but the one named by enter_at.
   bit guard_at[PROG_DEPTH];
   int enter_at = -1;
   int n_sent;
   int n_restarts;
   bit pressure_done;

   always #10 clock = ~clock;

   // Idling runs in four phases that rotate every hundred beats: none, the
   // sender idles, the receiver stalls, and both do at a lower rate.
   function automatic int req_gap_pct();
      case ((n_sent / 100) % 4)
         1: return 68;
         3: return 27;
         default: return 0;
      endcase
   endfunction

   function automatic int rsp_gap_pct();
      case ((n_sent / 100) % 4)
         2: return 68;
         3: return 27;
         default: return 0;
      endcase
   endfunction

   // Offers one step request and returns once the beat has been taken.
   // Valid stays high between back-to-back beats, so it gets one assignment
   // per edge.
   task automatic send_step(input logic [1:0] m, input logic [7:0] c, input logic [7:0] b);
      while ($urandom_range(99) < req_gap_pct()) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= m;
      req_bus.code_byte  <= c;
      req_bus.input_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(m, c, b);
      n_sent++;
   endtask

   task automatic restart_run();
      send_step(MODE_RESTART, 8'($urandom), 8'($urandom));
      n_restarts++;
   endtask

   // One execute step. The input byte is chosen from the instruction that
   // will run: guards get zero unless their block is to be entered.
   task automatic exec_one();
      logic [7:0] v;
      v = 8'($urandom);
      if (sb.pc < sb.plen && sb.store[sb.pc] == OP_IN) begin
         if (guard_at[sb.pc]) begin
            if (sb.pc != enter_at) v = 8'd0;
            else if ($urandom_range(15) == 0) v = 8'hFF;
            else v = 8'($urandom_range(1, 4));
         end else if ($urandom_range(3) != 0) begin
            v = 8'($urandom_range(0, 5));
         end
      end
      send_step(MODE_EXEC, 8'($urandom), v);
   endtask

   task automatic run_steps(input int budget);
      while (sb.st == STAT_RUN && budget > 0) begin
         if ($urandom_range(19) == 0) send_step(MODE_IDLE, 8'($urandom), 8'($urandom));
         exec_one();
         budget--;
      end
   endtask

   task automatic append_guarded(input logic [7:0] body[$], output int addr);
      addr = sb.plen;
      guard_at[addr] = 1'b1;
      send_step(MODE_APPEND, OP_IN, 8'($urandom));
      send_step(MODE_APPEND, OP_OPEN, 8'($urandom));
      foreach (body[i]) send_step(MODE_APPEND, body[i], 8'($urandom));
      send_step(MODE_APPEND, OP_CLOSE, 8'($urandom));
   endtask

   // Random block body. Brackets always balance so that a guard can skip
   // the block; pointer moves mostly come in pairs, but a lone one now and
   // then lets the pointer errors happen in the middle of a run.
   function automatic void grow_body(input int lvl, ref logic [7:0] q[$]);
      logic [7:0] x;
      repeat ($urandom_range(1, 5)) begin
         case ($urandom_range(0, 19))
            0, 1, 2: q.push_back(OP_INC);
            3, 4: q.push_back(OP_DEC);
            5, 6: q.push_back(OP_OUT);
            7, 8: q.push_back(OP_IN);
            9, 10: begin
               do x = 8'($urandom);
               while (x inside {OP_INC, OP_DEC, OP_RIGHT, OP_LEFT,
                                OP_OUT, OP_IN, OP_OPEN, OP_CLOSE});
               q.push_back(x);
            end
            11, 12, 13: begin
               q.push_back(OP_RIGHT);
               q.push_back($urandom_range(1) ? OP_INC : OP_OUT);
               q.push_back(OP_LEFT);
            end
            14: q.push_back($urandom_range(1) ? OP_RIGHT : OP_LEFT);
            default: begin
               if (lvl < 3) begin
                  q.push_back(OP_OPEN);
                  grow_body(lvl + 1, q);
                  q.push_back(OP_DEC);
                  q.push_back(OP_CLOSE);
               end else q.push_back(OP_INC);
            end
         endcase
      end
   endfunction

   // Enters one error block from a fresh run, pokes the stopped machine,
   // then replays to the end of the program with every block skipped.
   task automatic provoke(input int guard, input int budget);
      enter_at = guard;
      restart_run();
      run_steps(budget);
      exec_one();
      enter_at = -1;
      restart_run();
      run_steps(4000);
   endtask

   // Result side: checks every beat and drives ready. Once, after some
   // traffic, it holds ready low for a long stretch so the core backs up
   // and stops taking requests.
   initial begin
      int hold;
      hold = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.out_valid, rsp_bus.out_byte,
                            rsp_bus.input_taken, rsp_bus.status);
         if (!pressure_done && n_sent >= 500) begin
            pressure_done = 1'b1;
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_gap_pct());
         end
      end
   end

   // Watchdog: a long run of cycles with no beat on either side is a hang.
   // The limit covers the clearing sweep after reset and a restart, a
   // forward skip across the full program store, and the long receiver hold.
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle = 0;
         else
            idle++;
         if (idle >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [7:0] body[$];
      int         addr;
      int         g_under;
      int         g_full;
      int         g_ovf;
      int         chunks;

      reset <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.mode       <= MODE_IDLE;
      req_bus.code_byte  <= 8'd0;
      req_bus.input_byte <= 8'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty store: a no-op step, then executing past the end twice.
      send_step(MODE_IDLE, 8'hFF, 8'hFF);
      send_step(MODE_EXEC, 8'h00, 8'h00);
      send_step(MODE_EXEC, 8'hFF, 8'hFF);

      // Error blocks, reached only when their guard is entered: '<' at
      // cell zero, a bracket nest one deeper than the stack, and a loop that
      // marches the pointer off the end of the tape.
      body = '{OP_LEFT};
      append_guarded(body, g_under);
      body.delete();
      repeat (32) body.push_back(OP_OPEN);
      repeat (32) body.push_back(OP_CLOSE);
      append_guarded(body, g_full);
      body.delete();
      repeat (64) body.push_back(OP_RIGHT);
      body.push_back(OP_INC);
      append_guarded(body, g_ovf);

      // One block with every instruction, a loop that runs, a loop that is
      // skipped on a zero cell, and two bytes that are not instructions.
      body = '{OP_RIGHT, OP_INC, OP_OUT, OP_LEFT, OP_IN, OP_OUT,
               OP_OPEN, OP_OUT, OP_DEC, OP_CLOSE, OP_OPEN, OP_INC, OP_CLOSE,
               8'h00, 8'hFF};
      append_guarded(body, addr);
      enter_at = addr;
      run_steps(1000);
      send_step(MODE_EXEC, 8'($urandom), 8'($urandom));

      // Random blocks. Each one is appended at the end of the program and
      // run; after an error or a runaway loop the run restarts and replays.
      chunks = 0;
      while (n_sent < ITEMS && sb.plen < 3300) begin
         body.delete();
         grow_body(0, body);
         append_guarded(body, addr);
         chunks++;
         enter_at = addr;
         if (sb.st != STAT_RUN || sb.pc != addr) restart_run();
         run_steps(600);
         if (sb.st == STAT_RUN) begin
            enter_at = -1;
            restart_run();
            run_steps(4000);
         end
         if (sb.st == STAT_DONE && $urandom_range(7) == 0) begin
            exec_one();
            send_step(MODE_IDLE, 8'($urandom), 8'($urandom));
         end
         if (chunks % 20 == 0) provoke((chunks % 40 == 0) ? g_full : g_under, 400);
      end

      // The long pointer march to the tape end, once.
      provoke(g_ovf, 6000);

      // A guard whose bracket has no match yet: the skip runs off the end.
      // Closing it afterwards, while stopped, makes it skippable again.
      addr = sb.plen;
      guard_at[addr] = 1'b1;
      enter_at = -1;
      send_step(MODE_APPEND, OP_IN, 8'($urandom));
      send_step(MODE_APPEND, OP_OPEN, 8'($urandom));
      run_steps(10);
      exec_one();
      send_step(MODE_APPEND, OP_DEC, 8'($urandom));
      send_step(MODE_APPEND, OP_CLOSE, 8'($urandom));
      restart_run();
      run_steps(4000);

      // A close bracket with nothing on the stack.
      send_step(MODE_APPEND, OP_CLOSE, 8'($urandom));
      run_steps(10);

      // Fill the program store from a clean status, then overrun it.
      restart_run();
      while (sb.plen < PROG_DEPTH) send_step(MODE_APPEND, 8'($urandom), 8'($urandom));
      repeat (3) send_step(MODE_APPEND, 8'($urandom), 8'($urandom));
      exec_one();
      send_step(MODE_IDLE, 8'($urandom), 8'($urandom));

      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Ran %0d steps over %0d program bytes with %0d restarts;",
               n_sent, sb.plen, n_restarts);
      $display("%0d result beats compared, %0d field mismatches.", sb.n_checked, sb.n_bad);
      if (sb.n_bad == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> files.f
rtl/bftm_pkg.sv
rtl/bftm_if.sv
rtl/bftm_ram.sv
rtl/bftm_stack.sv
rtl/bf_tape_machine_core.sv
rtl/bftm_checker.sv
test/tb.sv
